/* hw/rtl/protobuf_field_encoder_assert.svh */
// ----------------------------------------------------------------------------
// Protobuf field encoder assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef PROTOBUF_FIELD_ENCODER_ASSERT_SVH
`define PROTOBUF_FIELD_ENCODER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PBFE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PBFE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/pbfe_pkg.sv */
// ----------------------------------------------------------------------------
// Protobuf field encoder package
// Command codes, stage records and the varint encoding function.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pbfe_pkg;

	typedef enum logic [3:0] {
		CMD_BOOL   = 4'd0,
		CMD_INT32  = 4'd1,
		CMD_UINT32 = 4'd2,
		CMD_INT64  = 4'd3,
		CMD_UINT64 = 4'd4,
		CMD_FLOAT  = 4'd5,
		CMD_DOUBLE = 4'd6,
		CMD_STRING = 4'd7,
		CMD_RAW    = 4'd8
	} cmd_t;

	typedef enum logic [2:0] {
		WIRE_VARINT  = 3'd0,
		WIRE_FIXED64 = 3'd1,
		WIRE_LENGTH  = 3'd2,
		WIRE_FIXED32 = 3'd5
	} wire_t;

	typedef enum logic [1:0] {
		PAY_VARINT = 2'd0,
		PAY_FIX4   = 2'd1,
		PAY_FIX8   = 2'd2,
		PAY_RAW    = 2'd3
	} pay_mode_t;

	localparam logic [7:0] CONT_BIT  = 8'h80;
	localparam int         MAX_BYTES = 15;

	// Decoded item after stage 1.
	typedef struct packed {
		logic        nul;
		logic        err;
		logic        has_tag;
		pay_mode_t   mode;
		logic [31:0] tag;
		logic [63:0] pay;
	} dec_t;

	// Varint encoding of up to 64 bits: ten bytes and a length of 1 to 10.
	typedef struct packed {
		logic [9:0][7:0] b;
		logic [3:0]      len;
	} vi_t;

	// Encoded tag and payload after stage 2.
	typedef struct packed {
		logic            nul;
		logic            err;
		logic [4:0][7:0] tag_b;
		logic [2:0]      tag_len;
		logic [9:0][7:0] pay_b;
		logic [3:0]      pay_len;
	} enc_t;

	// Packed byte string after stage 3; a length of zero drops the item.
	typedef struct packed {
		logic [MAX_BYTES-1:0][7:0] b;
		logic [3:0]                len;
		logic                      err;
	} pack_t;

	function automatic vi_t varint_enc(input logic [63:0] v);
		vi_t             r;
		logic [9:0][6:0] g;
		for (int i = 0; i < 9; i++) begin
			g[i] = v[7*i +: 7];
		end
		g[9] = {6'b0, v[63]};
		r.len = 4'd1;
		for (int i = 1; i < 10; i++) begin
			if (|g[i]) begin
				r.len = 4'(i + 1);
			end
		end
		for (int i = 0; i < 10; i++) begin
			r.b[i] = {1'b0, g[i]} | ((4'(i + 1) < r.len) ? CONT_BIT : 8'h00);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/pbfe_decode.sv */
// ----------------------------------------------------------------------------
// Protobuf field encoder decode stage
// Checks the command and size, extends the value and forms the tag word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pbfe_decode import pbfe_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        up_valid,
	output logic             up_stall,
	input  wire logic [3:0]  cmd,
	input  wire logic [28:0] field_number,
	input  wire logic [1:0]  src_size,
	input  wire logic [63:0] value,
	input  wire logic        is_null,
	output logic             dn_valid,
	input  wire logic        dn_stall,
	output dec_t             dn_data
);

	logic        v_s1;
	dec_t        d_s1;
	dec_t        d;
	logic [63:0] sx;
	logic [63:0] zx;
	wire_t       wt;

	always_comb begin
		case (src_size)
			2'd0: sx = {{56{value[7]}}, value[7:0]};
			2'd1: sx = {{48{value[15]}}, value[15:0]};
			2'd2: sx = {{32{value[31]}}, value[31:0]};
			default: sx = value;
		endcase
		case (src_size)
			2'd0: zx = {56'b0, value[7:0]};
			2'd1: zx = {48'b0, value[15:0]};
			2'd2: zx = {32'b0, value[31:0]};
			default: zx = value;
		endcase
	end

	always_comb begin
		d.nul     = is_null;
		d.err     = 1'b0;
		d.has_tag = 1'b1;
		d.mode    = PAY_VARINT;
		d.pay     = zx;
		wt        = WIRE_VARINT;
		unique case (cmd) inside
			CMD_BOOL: begin
				d.err = (src_size != 2'd0);
				d.pay = {63'b0, |value[7:0]};
			end
			CMD_INT32, CMD_UINT32: begin
				d.err = (src_size == 2'd3);
				d.pay = (cmd == CMD_INT32) ? {32'b0, sx[31:0]} : zx;
			end
			CMD_INT64: d.pay = sx;
			CMD_UINT64: d.pay = zx;
			CMD_FLOAT: begin
				wt     = WIRE_FIXED32;
				d.mode = PAY_FIX4;
				d.pay  = value;
			end
			CMD_DOUBLE: begin
				wt     = WIRE_FIXED64;
				d.mode = PAY_FIX8;
				d.pay  = value;
			end
			CMD_STRING: begin
				wt    = WIRE_LENGTH;
				d.err = |value[63:32];
				d.pay = value;
			end
			CMD_RAW: begin
				d.has_tag = 1'b0;
				d.mode    = PAY_RAW;
				d.pay     = value;
			end
			default: d.err = 1'b1;
		endcase
		d.tag = {field_number, wt};
	end

	assign up_stall = v_s1 & dn_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!up_stall) begin
			v_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!up_stall && up_valid) begin
			d_s1 <= d;
		end
	end

	assign dn_valid = v_s1;
	assign dn_data  = d_s1;

endmodule

`default_nettype wire

/* hw/rtl/pbfe_varint.sv */
// ----------------------------------------------------------------------------
// Protobuf field encoder varint stage
// Encodes the tag and the payload into byte groups with their lengths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pbfe_varint import pbfe_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic up_valid,
	output logic      up_stall,
	input  wire dec_t up_data,
	output logic      dn_valid,
	input  wire logic dn_stall,
	output enc_t      dn_data
);

	logic v_s2;
	enc_t d_s2;
	enc_t e;
	vi_t  tv;
	vi_t  pv;

	always_comb begin
		tv        = varint_enc({32'b0, up_data.tag});
		pv        = varint_enc(up_data.pay);
		e.nul     = up_data.nul;
		e.err     = up_data.err;
		e.tag_b   = tv.b[4:0];
		e.tag_len = up_data.has_tag ? tv.len[2:0] : 3'd0;
		e.pay_b   = '0;
		e.pay_len = 4'd0;
		case (up_data.mode)
			PAY_VARINT: begin
				e.pay_b   = pv.b;
				e.pay_len = pv.len;
			end
			PAY_FIX4: begin
				for (int i = 0; i < 4; i++) begin
					e.pay_b[i] = up_data.pay[8*i +: 8];
				end
				e.pay_len = 4'd4;
			end
			PAY_FIX8: begin
				for (int i = 0; i < 8; i++) begin
					e.pay_b[i] = up_data.pay[8*i +: 8];
				end
				e.pay_len = 4'd8;
			end
			default: begin
				e.pay_b[0] = up_data.pay[7:0];
				e.pay_len  = 4'd1;
			end
		endcase
	end

	assign up_stall = v_s2 & dn_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (!up_stall) begin
			v_s2 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!up_stall && up_valid) begin
			d_s2 <= e;
		end
	end

	assign dn_valid = v_s2;
	assign dn_data  = d_s2;

endmodule

`default_nettype wire

/* hw/rtl/pbfe_pack.sv */
// ----------------------------------------------------------------------------
// Protobuf field encoder pack stage
// Joins tag and payload bytes into one byte string, or forms the error byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pbfe_pack import pbfe_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic up_valid,
	output logic      up_stall,
	input  wire enc_t up_data,
	output logic      dn_valid,
	input  wire logic dn_stall,
	output pack_t     dn_data
);

	logic                      v_s3;
	pack_t                     d_s3;
	pack_t                     p;
	logic [MAX_BYTES-1:0][7:0] pay_wide;
	logic [MAX_BYTES-1:0][7:0] pay_shift;

	always_comb begin
		pay_wide  = (8*MAX_BYTES)'(up_data.pay_b);
		pay_shift = pay_wide << {up_data.tag_len, 3'b000};
		p.b       = pay_shift;
		for (int j = 0; j < 5; j++) begin
			if (3'(j) < up_data.tag_len) begin
				p.b[j] = up_data.tag_b[j];
			end
		end
		p.len = {1'b0, up_data.tag_len} + up_data.pay_len;
		p.err = 1'b0;
		if (up_data.nul) begin
			p.len = 4'd0;
		end else if (up_data.err) begin
			p.b   = '0;
			p.len = 4'd1;
			p.err = 1'b1;
		end
	end

	assign up_stall = v_s3 & dn_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (!up_stall) begin
			v_s3 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!up_stall && up_valid) begin
			d_s3 <= p;
		end
	end

	assign dn_valid = v_s3;
	assign dn_data  = d_s3;

endmodule

`default_nettype wire

/* hw/rtl/pbfe_serial.sv */
// ----------------------------------------------------------------------------
// Protobuf field encoder serializer
// Shifts a byte string into the output register, one byte per unstalled cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pbfe_serial import pbfe_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        up_valid,
	output logic             up_stall,
	input  wire pack_t       up_data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       out_byte,
	output logic             last,
	output logic             error
);

	logic [MAX_BYTES-1:0][7:0] buf_q;
	logic [3:0]                rem_q;
	logic                      err_q;
	logic                      valid_q;
	logic [7:0]                byte_q;
	logic                      last_q;
	logic                      error_q;
	logic                      free;
	logic                      emit;
	logic                      load;

	assign free     = !valid_q || !out_stall;
	assign emit     = (rem_q != 4'd0) && free;
	// A new string loads when the buffer is empty or its final byte leaves now.
	assign load     = up_valid && ((rem_q == 4'd0) || (emit && rem_q == 4'd1));
	assign up_stall = up_valid && !load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q   <= 4'd0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				rem_q <= up_data.len;
			end else if (emit) begin
				rem_q <= rem_q - 4'd1;
			end
			if (emit) begin
				valid_q <= 1'b1;
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			buf_q <= up_data.b;
			err_q <= up_data.err;
		end else if (emit) begin
			buf_q <= {8'h00, buf_q[MAX_BYTES-1:1]};
		end
		if (emit) begin
			byte_q  <= buf_q[0];
			last_q  <= (rem_q == 4'd1);
			error_q <= err_q;
		end
	end

	assign out_valid = valid_q;
	assign out_byte  = byte_q;
	assign last      = last_q;
	assign error     = error_q;

endmodule

`default_nettype wire

/* hw/rtl/protobuf_field_encoder.sv */
// ----------------------------------------------------------------------------
// Protobuf field encoder
// Turns one column value per transaction into protobuf wire-format bytes.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid, in_stall) carries one column value per
// transaction: cmd, field_number, src_size, value and is_null. The output
// channel (out_valid, out_stall) carries one encoded byte per transaction,
// with last set on the final byte of an item and error set on the single
// zero byte that replaces a rejected item. A null item produces no output.
// Order: an item passes through the decode, varint, pack and serializer
// stages before its first byte appears on the output.
// Throughput: an item of 1 to 15 bytes occupies the byte-wide serializer
// until its final byte has left, and items follow each other without gaps,
// so while out_stall is low the sustained rate is one output byte per cycle.
// A null item takes a pipeline slot and a serializer load but makes no byte.
// Reset: arst_n clears every stage valid bit and the serializer count; the
// block accepts input as soon as reset is released.
// Stall: when out_stall holds the output register, the serializer holds its
// buffer, and backpressure reaches in_stall stage by stage, only where a
// stage still holds an item. No transaction is lost or repeated.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "protobuf_field_encoder_assert.svh"

module protobuf_field_encoder import pbfe_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [3:0]  cmd,
	input  wire logic [28:0] field_number,
	input  wire logic [1:0]  src_size,
	input  wire logic [63:0] value,
	input  wire logic        is_null,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       out_byte,
	output logic             last,
	output logic             error
);

	// Stage handshakes: each of stages 1 to 3 stalls upstream only while it is
	// full and its own downstream neighbor stalls.
	logic  v_s1;
	logic  stall_s1;
	dec_t  d_s1;
	logic  v_s2;
	logic  stall_s2;
	enc_t  d_s2;
	logic  v_s3;
	logic  stall_s3;
	pack_t d_s3;

	// Stage 1 validates the command against the source size, sign- or
	// zero-extends the value and builds the 32-bit tag word.
	pbfe_decode u_decode (
		.clk          (clk),
		.arst_n       (arst_n),
		.up_valid     (in_valid),
		.up_stall     (in_stall),
		.cmd          (cmd),
		.field_number (field_number),
		.src_size     (src_size),
		.value        (value),
		.is_null      (is_null),
		.dn_valid     (v_s1),
		.dn_stall     (stall_s1),
		.dn_data      (d_s1)
	);

	// Stage 2 splits tag and payload into 7-bit groups with continuation
	// bits, or lays out the fixed-width little-endian bytes or the single raw byte.
	pbfe_varint u_varint (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (v_s1),
		.up_stall (stall_s1),
		.up_data  (d_s1),
		.dn_valid (v_s2),
		.dn_stall (stall_s2),
		.dn_data  (d_s2)
	);

	// Stage 3 places the payload right after the tag bytes, or forms the error byte.
	pbfe_pack u_pack (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (v_s2),
		.up_stall (stall_s2),
		.up_data  (d_s2),
		.dn_valid (v_s3),
		.dn_stall (stall_s3),
		.dn_data  (d_s3)
	);

	// The serializer hands out one byte per cycle while out_stall is low and
	// reloads on the cycle its final byte moves into the output register.
	pbfe_serial u_serial (
		.clk       (clk),
		.arst_n    (arst_n),
		.up_valid  (v_s3),
		.up_stall  (stall_s3),
		.up_data   (d_s3),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.last      (last),
		.error     (error)
	);

	`PBFE_ASSERT_SAME(a_err_is_last, clk, arst_n, out_valid && error, last, "error byte without last")
	`PBFE_ASSERT_SAME(a_err_is_zero, clk, arst_n, out_valid && error, out_byte == 8'h00, "error byte not zero")
	`PBFE_ASSERT_SAME(a_stall_needs_s1, clk, arst_n, in_stall, v_s1 && stall_s1, "input stalled with stage 1 free")
	`PBFE_ASSERT_NEXT(a_s3_holds, clk, arst_n, v_s3 && stall_s3, v_s3, "stage 3 item dropped while stalled")

endmodule

`default_nettype wire

/* dv/pbfe_wire_check.sv */
// ----------------------------------------------------------------------------
// Protobuf field encoder wire-format checker
// Watches both channels, predicts the encoded bytes of every column and
// compares each output byte with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pbfe_wire_check import pbfe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [3:0]  cmd,
	input  logic [28:0] field_number,
	input  logic [1:0]  src_size,
	input  logic [63:0] value,
	input  logic        is_null,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [7:0]  out_byte,
	input  logic        last,
	input  logic        error,
	output int          bytes_due,
	output int          mismatches
);

	typedef struct {
		logic [7:0] data;
		logic       last;
		logic       err;
	} wire_byte_t;

	wire_byte_t expected_bytes[$];
	logic [7:0] column_bytes[$];
	wire_byte_t want;
	int         errs;

	function automatic void add_column_byte(input logic [7:0] b);
		column_bytes.insert(column_bytes.size(), b);
	endfunction

	function automatic void add_expected(input logic [7:0] b, input logic l, input logic e);
		wire_byte_t w;
		w.data = b;
		w.last = l;
		w.err  = e;
		expected_bytes.insert(expected_bytes.size(), w);
	endfunction

	function automatic void append_varint(input logic [63:0] v);
		while (v > 64'h7F) begin
			add_column_byte({1'b1, v[6:0]});
			v = v >> 7;
		end
		add_column_byte({1'b0, v[6:0]});
	endfunction

	function automatic logic [63:0] widen(input logic [63:0] v, input logic [1:0] sz,
			input logic sgn);
		logic [63:0] r;
		case (sz)
			2'd0: r = {{56{sgn & v[7]}}, v[7:0]};
			2'd1: r = {{48{sgn & v[15]}}, v[15:0]};
			2'd2: r = {{32{sgn & v[31]}}, v[31:0]};
			default: r = v;
		endcase
		return r;
	endfunction

	function automatic void append_tag(input logic [28:0] fnum, input wire_t wt);
		append_varint({32'd0, fnum, wt});
	endfunction

	function automatic void encode_column(input logic [3:0] c, input logic [28:0] fnum,
			input logic [1:0] sz, input logic [63:0] val, input logic nul);
		logic reject;
		reject = 1'b0;
		column_bytes.delete();
		if (nul)
			return;
		case (c) inside
			CMD_BOOL: begin
				if (sz != 2'd0) begin
					reject = 1'b1;
				end else begin
					append_tag(fnum, WIRE_VARINT);
					add_column_byte({7'd0, |val[7:0]});
				end
			end
			CMD_INT32, CMD_UINT32: begin
				if (sz == 2'd3) begin
					reject = 1'b1;
				end else begin
					append_tag(fnum, WIRE_VARINT);
					append_varint(widen(val, sz, c == CMD_INT32) & 64'hFFFF_FFFF);
				end
			end
			CMD_INT64, CMD_UINT64: begin
				append_tag(fnum, WIRE_VARINT);
				append_varint(widen(val, sz, c == CMD_INT64));
			end
			CMD_FLOAT: begin
				append_tag(fnum, WIRE_FIXED32);
				for (int i = 0; i < 4; i++)
					add_column_byte(val[8*i +: 8]);
			end
			CMD_DOUBLE: begin
				append_tag(fnum, WIRE_FIXED64);
				for (int i = 0; i < 8; i++)
					add_column_byte(val[8*i +: 8]);
			end
			CMD_STRING: begin
				if (val[63:32] != 32'd0) begin
					reject = 1'b1;
				end else begin
					append_tag(fnum, WIRE_LENGTH);
					append_varint(val);
				end
			end
			CMD_RAW: add_column_byte(val[7:0]);
			default: reject = 1'b1;
		endcase
		if (reject) begin
			add_expected(8'h00, 1'b1, 1'b1);
		end else begin
			foreach (column_bytes[i])
				add_expected(column_bytes[i], i == column_bytes.size() - 1, 1'b0);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_bytes.delete();
			errs = 0;
			bytes_due <= 0;
			mismatches <= 0;
		end else begin
			if (in_valid && !in_stall)
				encode_column(cmd, field_number, src_size, value, is_null);
			if (out_valid && !out_stall) begin
				if (expected_bytes.size() == 0) begin
					errs++;
					$display("%0t: unexpected byte, expected none, actual %h last %b error %b",
						$time, out_byte, last, error);
				end else begin
					want = expected_bytes.pop_front();
					if (out_byte !== want.data) begin
						errs++;
						$display("%0t: out_byte expected %h actual %h", $time, want.data,
							out_byte);
					end
					if (last !== want.last) begin
						errs++;
						$display("%0t: last expected %b actual %b", $time, want.last, last);
					end
					if (error !== want.err) begin
						errs++;
						$display("%0t: error expected %b actual %b", $time, want.err, error);
					end
				end
			end
			bytes_due <= expected_bytes.size();
			mismatches <= errs;
		end
	end

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// Protobuf field encoder testbench
// Drives directed and random column values into the encoder, stalls the byte
// output at random and lets the wire-format checker judge every byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb import pbfe_pkg::*;;

	// Command codes the block does not know; they must be rejected.
	localparam logic [3:0]  CMD_BAD_LO = 4'd9;
	localparam logic [3:0]  CMD_BAD_HI = 4'd15;
	localparam logic [28:0] FNUM_MAX   = 29'h1FFF_FFFF;
	localparam int          TOTAL_ITEMS  = 270;
	localparam int          MAX_PAUSE    = 14;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid;
	logic        in_stall;
	logic [3:0]  cmd;
	logic [28:0] field_number;
	logic [1:0]  src_size;
	logic [63:0] value;
	logic        is_null;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  out_byte;
	logic        last;
	logic        error;
	int          bytes_due;
	int          mismatches;

	// Pause bookkeeping: while a calm counter runs, that side never idles.
	int          send_calm = 0;
	int          recv_calm = 0;
	int          sent_items = 0;

	protobuf_field_encoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.field_number (field_number),
		.src_size     (src_size),
		.value        (value),
		.is_null      (is_null),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.last         (last),
		.error        (error)
	);

	pbfe_wire_check chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.field_number (field_number),
		.src_size     (src_size),
		.value        (value),
		.is_null      (is_null),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.last         (last),
		.error        (error),
		.bytes_due    (bytes_due),
		.mismatches   (mismatches)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Number of idle cycles before the next transaction of one side. Now and
	// then a side enters a calm stretch of back-to-back transactions.
	function automatic int next_pause(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 9) == 0) begin
			calm = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, MAX_PAUSE);
	endfunction

	// Field numbers around the tag length boundaries, plus the full range.
	function automatic logic [28:0] pick_fnum();
		case ($urandom_range(0, 4))
			0: return 29'($urandom_range(0, 15));
			1: return 29'($urandom_range(16, 2047));
			2: return FNUM_MAX;
			default: return 29'($urandom);
		endcase
	endfunction

	// Values that hit the sign boundary of the source width, the varint
	// length boundaries and fully random bit patterns.
	function automatic logic [63:0] pick_value(input logic [1:0] sz);
		logic [63:0] edge_bit;
		edge_bit = 64'd1 << ((8 << sz) - 1);
		case ($urandom_range(0, 9))
			0: return 64'd0;
			1: return '1;
			2: return edge_bit;
			3: return edge_bit - 64'd1;
			4: return 64'($urandom_range(0, 127));
			5: return 64'd1 << $urandom_range(0, 63);
			6: return {$urandom, $urandom} >> $urandom_range(0, 63);
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Presents one column value and returns in the time step of the edge at
	// which the transaction is accepted.
	task automatic put_column(input logic [3:0] c, input logic [28:0] fnum,
			input logic [1:0] sz, input logic [63:0] val, input logic nul);
		int gap;
		gap = next_pause(send_calm);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		cmd          <= c;
		field_number <= fnum;
		src_size     <= sz;
		value        <= val;
		is_null      <= nul;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent_items++;
	endtask

	// Holds the input idle until every predicted byte has come out.
	task automatic hold_until_drained();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (bytes_due != 0);
	endtask

	// A string header followed by its bytes as raw-byte transactions.
	task automatic put_string();
		int len;
		len = $urandom_range(0, 12);
		put_column(CMD_STRING, pick_fnum(), 2'($urandom), 64'(len), 1'b0);
		repeat (len)
			put_column(CMD_RAW, 29'($urandom), 2'($urandom), {$urandom, $urandom}, 1'b0);
	endtask

	// Output side: stall for a random number of cycles before each byte.
	initial begin
		int stall_len;
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall_len = next_pause(recv_calm);
			if (stall_len > 0) begin
				out_stall <= 1'b1;
				repeat (stall_len) @(posedge clk);
			end
			out_stall <= 1'b0;
			do
				@(posedge clk);
			while (!out_valid);
		end
	end

	// Stimulus and verdict.
	initial begin
		logic [3:0] c;
		logic [1:0] sz;
		in_valid     <= 1'b0;
		cmd          <= CMD_BOOL;
		field_number <= '0;
		src_size     <= '0;
		value        <= '0;
		is_null      <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed columns: field and size extremes and every special case.
		put_column(CMD_BOOL,   29'd1,    2'd0, 64'd0, 1'b0);
		put_column(CMD_BOOL,   FNUM_MAX, 2'd0, 64'h100, 1'b0); // low byte zero means false
		put_column(CMD_BOOL,   29'd0,    2'd0, 64'hFF, 1'b0);
		put_column(CMD_BOOL,   29'd5,    2'd2, 64'd1, 1'b0);   // bool wider than a byte
		put_column(CMD_INT32,  29'd2,    2'd0, 64'h80, 1'b0);  // negative, short form
		put_column(CMD_INT32,  29'd16,   2'd1, 64'h7FFF, 1'b0);
		put_column(CMD_INT32,  29'd3,    2'd2, 64'h8000_0000, 1'b0);
		put_column(CMD_INT32,  29'd3,    2'd3, 64'd7, 1'b0);   // eight-byte source rejected
		put_column(CMD_UINT32, 29'd4,    2'd2, '1, 1'b0);
		put_column(CMD_UINT32, 29'd4,    2'd0, 64'hDEAD_BEEF_0000_00FF, 1'b0);
		put_column(CMD_UINT32, 29'd4,    2'd3, 64'd1, 1'b0);
		put_column(CMD_INT64,  FNUM_MAX, 2'd3, '1, 1'b0);      // longest output
		put_column(CMD_INT64,  29'd6,    2'd0, 64'h80, 1'b0);
		put_column(CMD_UINT64, 29'd7,    2'd3, 64'd0, 1'b0);
		put_column(CMD_UINT64, 29'd7,    2'd1, '1, 1'b0);
		put_column(CMD_FLOAT,  29'd8,    2'd3, 64'h0123_4567_89AB_CDEF, 1'b0);
		put_column(CMD_DOUBLE, FNUM_MAX, 2'd0, '1, 1'b0);
		put_column(CMD_STRING, 29'd9,    2'd0, 64'd0, 1'b0);
		put_column(CMD_STRING, 29'd9,    2'd1, 64'hFFFF_FFFF, 1'b0);
		put_column(CMD_STRING, 29'd9,    2'd2, 64'h1_0000_0000, 1'b0); // length too long
		put_column(CMD_RAW,    29'd0,    2'd3, 64'hA5, 1'b0);
		put_column(CMD_RAW,    FNUM_MAX, 2'd0, 64'hFFFF_FFFF_FFFF_FF00, 1'b0);
		put_column(CMD_INT64,  29'd1,    2'd3, '1, 1'b1);      // null column
		put_column(CMD_RAW,    29'd1,    2'd0, 64'h5A, 1'b1);  // null raw byte
		put_column(CMD_BAD_LO, 29'd1,    2'd0, 64'd0, 1'b0);
		put_column(CMD_BAD_HI, FNUM_MAX, 2'd3, '1, 1'b0);

		// At least once the input waits for the output to run dry.
		hold_until_drained();

		// Random part: mostly well-formed columns and strings, some noise.
		while (sent_items < TOTAL_ITEMS) begin
			if (sent_items > TOTAL_ITEMS / 2 && $urandom_range(0, 39) == 0)
				hold_until_drained();
			case ($urandom_range(0, 9))
				0, 1, 2: put_string();
				3, 4, 5, 6, 7: begin
					c  = 4'($urandom_range(0, int'(CMD_RAW)));
					sz = 2'($urandom);
					put_column(c, pick_fnum(), sz, pick_value(sz), $urandom_range(0, 11) == 0);
				end
				8: begin
					// Unknown commands, a stray string header or an int32 of random source size.
					case ($urandom_range(0, 2))
						0: c = 4'($urandom_range(int'(CMD_BAD_LO), int'(CMD_BAD_HI)));
						1: c = CMD_STRING;
						default: c = CMD_INT32;
					endcase
					sz = 2'($urandom);
					put_column(c, pick_fnum(), sz, pick_value(sz), 1'b0);
				end
				default: put_column(4'($urandom), 29'($urandom), 2'($urandom),
					{$urandom, $urandom}, 1'b1);
			endcase
		end

		hold_until_drained();
		// Keep the clock running so that a stray byte after the last one is caught.
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
